@@ hw/rtl/avpg_pkg.sv @@
// Shared types, constants and palette tables for the attribute video pixel generator.
package avpg_pkg;

    localparam int SCREEN_PIXELS_WIDE = 256;
    localparam int SCREEN_LINES       = 192;
    localparam int CELLS_PER_LINE     = SCREEN_PIXELS_WIDE / 8;
    localparam int BITMAP_BYTES       = CELLS_PER_LINE * SCREEN_LINES;
    localparam int ATTR_BYTES         = CELLS_PER_LINE * (SCREEN_LINES / 8);
    localparam int STORE_BYTES        = BITMAP_BYTES + ATTR_BYTES;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_RENDER = 1'b1;

    localparam logic [1:0] PAL_STANDARD  = 2'd0;
    localparam logic [1:0] PAL_ALTERNATE = 2'd1;

    typedef logic [23:0] t_rgb;

    typedef struct packed {
        logic [7:0] bits;
        logic [7:0] attr;
        logic [4:0] column;
        logic [7:0] line;
        logic       phase;
    } t_cell;

    localparam t_rgb PAL_STD_TAB [16] = '{
        24'h000000, 24'h0000C0, 24'hC00000, 24'hC000C0,
        24'h00C000, 24'h00C0C0, 24'hC0C000, 24'hC0C0C0,
        24'h000000, 24'h6060FF, 24'hFF6060, 24'hFF60FF,
        24'h60FF60, 24'h60FFFF, 24'hFFFF60, 24'hFFFFFF
    };

    localparam t_rgb PAL_ALT_TAB [16] = '{
        24'h000000, 24'h0000CD, 24'hA70000, 24'hA700CD,
        24'h00B700, 24'h00B7CD, 24'hA7B700, 24'hA7B7CD,
        24'h000000, 24'h0000FF, 24'hD00000, 24'hD000FF,
        24'h00E400, 24'h00E4FF, 24'hD0E400, 24'hD0E4FF
    };

    localparam t_rgb PAL_MONO_TAB [16] = '{
        24'h3E414C, 24'h4E515F, 24'h5E6273, 24'h6E7386,
        24'h7E839A, 24'h8E94AD, 24'h9EA4C1, 24'hAEB5D4,
        24'h3E414C, 24'h525564, 24'h666A7C, 24'h7A7F94,
        24'h8E93AD, 24'hA2A8C5, 24'hB5BCDD, 24'hC9D1F6
    };

    // red in the top byte, blue in the low byte
    function automatic t_rgb palette_rgb(input logic [1:0] pal, input logic [3:0] idx);
        t_rgb c;
        case (pal)
            PAL_STANDARD:  c = PAL_STD_TAB[idx];
            PAL_ALTERNATE: c = PAL_ALT_TAB[idx];
            default:       c = PAL_MONO_TAB[idx];
        endcase
        return c;
    endfunction

endpackage

@@ hw/rtl/avpg_store.sv @@
// Display store: bitmap and attribute memories with one write and registered reads.
module avpg_store (
    input  logic        i_clk,
    input  logic        i_wr_en,
    input  logic [12:0] i_wr_addr,
    input  logic [7:0]  i_wr_data,
    input  logic        i_rd_en,
    input  logic [12:0] i_rd_bitmap_addr,
    input  logic [9:0]  i_rd_attr_addr,
    output logic [7:0]  o_rd_bits,
    output logic [7:0]  o_rd_attr
);

    logic [7:0] r_bitmap_mem [avpg_pkg::BITMAP_BYTES];
    logic [7:0] r_attr_mem   [avpg_pkg::ATTR_BYTES];
    logic [7:0] r_rd_bits;
    logic [7:0] r_rd_attr;
    logic       bitmap_we;
    logic       attr_we;

    assign bitmap_we = i_wr_en && (i_wr_addr < 13'(avpg_pkg::BITMAP_BYTES));
    assign attr_we   = i_wr_en && (i_wr_addr >= 13'(avpg_pkg::BITMAP_BYTES))
                               && (i_wr_addr < 13'(avpg_pkg::STORE_BYTES));

    always_ff @(posedge i_clk) begin
        if (bitmap_we) begin
            r_bitmap_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_bits <= r_bitmap_mem[i_rd_bitmap_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (attr_we) begin
            r_attr_mem[i_wr_addr[9:0]] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_attr <= r_attr_mem[i_rd_attr_addr];
        end
    end

    assign o_rd_bits = r_rd_bits;
    assign o_rd_attr = r_rd_attr;

endmodule

@@ hw/rtl/avpg_serial.sv @@
// Pixel serialiser: shifts one cell out as eight coloured pixels into an output register.
module avpg_serial (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  avpg_pkg::t_cell     i_cell,
    input  logic [1:0]          i_palette,
    output logic                o_take,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [7:0]          o_red,
    output logic [7:0]          o_green,
    output logic [7:0]          o_blue,
    output logic [7:0]          o_pixel_x,
    output logic [7:0]          o_pixel_y,
    output logic                o_last
);

    logic           r_sv;
    logic [2:0]     r_cnt;
    logic [7:0]     r_bits;
    logic [2:0]     r_ink;
    logic [2:0]     r_paper;
    logic           r_bright;
    logic           r_flip;
    logic [4:0]     r_col;
    logic [7:0]     r_line;

    logic           r_ov;
    logic [7:0]     r_red;
    logic [7:0]     r_green;
    logic [7:0]     r_blue;
    logic [7:0]     r_px;
    logic [7:0]     r_py;
    logic           r_last;

    logic           out_free;
    logic           emit;
    logic           take;
    logic [3:0]     idx;
    avpg_pkg::t_rgb rgb;

    assign out_free = !r_ov || i_ready;
    assign emit     = r_sv && out_free;
    assign take     = !r_sv || (emit && (r_cnt == 3'd7));
    assign idx      = {r_bright, (r_bits[7] ^ r_flip) ? r_ink : r_paper};
    assign rgb      = avpg_pkg::palette_rgb(i_palette, idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv  <= 1'b0;
            r_cnt <= 3'd0;
        end else if (i_load && take) begin
            r_sv  <= 1'b1;
            r_cnt <= 3'd0;
        end else if (emit) begin
            r_sv  <= (r_cnt != 3'd7);
            r_cnt <= r_cnt + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && take) begin
            r_bits   <= i_cell.bits;
            r_ink    <= i_cell.attr[2:0];
            r_paper  <= i_cell.attr[5:3];
            r_bright <= i_cell.attr[6];
            r_flip   <= i_cell.attr[7] & i_cell.phase;
            r_col    <= i_cell.column;
            r_line   <= i_cell.line;
        end else if (emit) begin
            r_bits <= {r_bits[6:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_free) begin
            r_ov <= r_sv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_red   <= rgb[23:16];
            r_green <= rgb[15:8];
            r_blue  <= rgb[7:0];
            r_px    <= {r_col, r_cnt};
            r_py    <= r_line;
            r_last  <= (r_cnt == 3'd7);
        end
    end

    assign o_take    = take;
    assign o_valid   = r_ov;
    assign o_red     = r_red;
    assign o_green   = r_green;
    assign o_blue    = r_blue;
    assign o_pixel_x = r_px;
    assign o_pixel_y = r_py;
    assign o_last    = r_last;

endmodule

@@ hw/rtl/attribute_video_pixel_generator.sv @@
// Top level: attribute video pixel generator with stream ports and palette register.
// A render beat passes through the store read register, the serialiser and its output register,
// then leaves one pixel a cycle unless m_axis_tready stalls it; a next render waits in the read register.
// Write beats are stored at the edge that accepts them.
// Reset clears the palette select to standard and empties the pipeline;
// the display store is not cleared and must be written before it is rendered.
module attribute_video_pixel_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // address[12:0], write_data[20:13], cell_column[25:21], line[33:26],
    // flash_phase[34], zero[39:35]
    input  logic [39:0] s_axis_tdata,
    // command[0]
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // red[7:0], green[15:8], blue[23:16], pixel_x[31:24], pixel_y[39:32]
    output logic [39:0] m_axis_tdata,
    output logic        m_axis_tlast
);

    logic [1:0]      r_palette;
    logic            r_av;
    logic [4:0]      r_col;
    logic [7:0]      r_line;
    logic            r_phase;

    logic [12:0]     in_address;
    logic [7:0]      in_write_data;
    logic [4:0]      in_column;
    logic [7:0]      in_line;
    logic            in_phase;
    logic            accept;
    logic            wr_acc;
    logic            rd_acc;
    logic            take;
    logic [7:0]      rd_bits;
    logic [7:0]      rd_attr;
    avpg_pkg::t_cell cell_data;
    logic [7:0]      red;
    logic [7:0]      green;
    logic [7:0]      blue;
    logic [7:0]      pixel_x;
    logic [7:0]      pixel_y;

    assign in_address    = s_axis_tdata[12:0];
    assign in_write_data = s_axis_tdata[20:13];
    assign in_column     = s_axis_tdata[25:21];
    assign in_line       = s_axis_tdata[33:26];
    assign in_phase      = s_axis_tdata[34];

    assign s_axis_tready = !r_av || take;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign wr_acc        = accept && (s_axis_tuser == avpg_pkg::CMD_WRITE);
    assign rd_acc        = accept && (s_axis_tuser == avpg_pkg::CMD_RENDER)
                                  && (in_line < 8'(avpg_pkg::SCREEN_LINES));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_palette <= avpg_pkg::PAL_STANDARD;
        end else if (i_cfg_wr_en) begin
            r_palette <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_av <= 1'b0;
        end else if (rd_acc) begin
            r_av <= 1'b1;
        end else if (take) begin
            r_av <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_acc) begin
            r_col   <= in_column;
            r_line  <= in_line;
            r_phase <= in_phase;
        end
    end

    avpg_store u_store (
        .i_clk            (i_clk),
        .i_wr_en          (wr_acc),
        .i_wr_addr        (in_address),
        .i_wr_data        (in_write_data),
        .i_rd_en          (rd_acc),
        .i_rd_bitmap_addr ({in_line[7:6], in_line[2:0], in_line[5:3], in_column}),
        .i_rd_attr_addr   ({in_line[7:3], in_column}),
        .o_rd_bits        (rd_bits),
        .o_rd_attr        (rd_attr)
    );

    assign cell_data.bits   = rd_bits;
    assign cell_data.attr   = rd_attr;
    assign cell_data.column = r_col;
    assign cell_data.line   = r_line;
    assign cell_data.phase  = r_phase;

    avpg_serial u_serial (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (r_av),
        .i_cell    (cell_data),
        .i_palette (r_palette),
        .o_take    (take),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_red     (red),
        .o_green   (green),
        .o_blue    (blue),
        .o_pixel_x (pixel_x),
        .o_pixel_y (pixel_y),
        .o_last    (m_axis_tlast)
    );

    assign m_axis_tdata = {pixel_y, pixel_x, blue, green, red};

    a_last_on_eighth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[26:24] == 3'd7)))
        else $error("last flag does not match pixel position");

    a_line_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[39:32] < 8'd192))
        else $error("pixel line out of range");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!m_axis_tvalid && s_axis_tready))
        else $error("pipeline not empty after reset");

endmodule

@@ tb/tb_attribute_video_pixel_generator.sv @@
// Self-checking testbench for the attribute video pixel generator: store writes, cell renders, palettes.
module tb_attribute_video_pixel_generator;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] PAL_MONO       = 2'd2;
    localparam logic [1:0] PAL_MONO_ALIAS = 2'd3;
    localparam int SETTLE_CYCLES   = 8;
    localparam int STALL_LIMIT     = 2000;
    localparam int ITEMS_PER_PHASE = 31;

    // {red, green, blue}
    localparam logic [23:0] SHADE [3][16] = '{
        '{24'h000000, 24'h0000C0, 24'hC00000, 24'hC000C0,
          24'h00C000, 24'h00C0C0, 24'hC0C000, 24'hC0C0C0,
          24'h000000, 24'h6060FF, 24'hFF6060, 24'hFF60FF,
          24'h60FF60, 24'h60FFFF, 24'hFFFF60, 24'hFFFFFF},
        '{24'h000000, 24'h0000CD, 24'hA70000, 24'hA700CD,
          24'h00B700, 24'h00B7CD, 24'hA7B700, 24'hA7B7CD,
          24'h000000, 24'h0000FF, 24'hD00000, 24'hD000FF,
          24'h00E400, 24'h00E4FF, 24'hD0E400, 24'hD0E4FF},
        '{24'h3E414C, 24'h4E515F, 24'h5E6273, 24'h6E7386,
          24'h7E839A, 24'h8E94AD, 24'h9EA4C1, 24'hAEB5D4,
          24'h3E414C, 24'h525564, 24'h666A7C, 24'h7A7F94,
          24'h8E93AD, 24'hA2A8C5, 24'hB5BCDD, 24'hC9D1F6}
    };

    typedef struct {
        logic        command;
        logic [12:0] address;
        logic [7:0]  write_data;
        logic [4:0]  cell_column;
        logic [7:0]  line;
        logic        flash_phase;
    } t_video_op;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] pixel_x;
        logic [7:0] pixel_y;
        logic       last;
    } t_pixel;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_wr_en   = 1'b0;
    logic [1:0]  i_cfg_wr_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;
    logic        s_axis_tuser  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tlast;

    t_video_op  pending_ops[$];
    t_video_op  op_on_bus;
    t_pixel     expected_pixels[$];
    logic [7:0] screen_copy [avpg_pkg::STORE_BYTES];
    logic [1:0] palette_copy = avpg_pkg::PAL_STANDARD;
    bit         byte_written [avpg_pkg::STORE_BYTES];
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    int         error_count   = 0;
    int         ops_counted   = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    attribute_video_pixel_generator i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    function automatic logic [12:0] bitmap_addr(input logic [4:0] col, input logic [7:0] ln);
        logic [12:0] linear;
        linear = {ln, 5'b0} + col;
        return {linear[12:11], linear[7:5], linear[10:8], linear[4:0]};
    endfunction

    function automatic logic [12:0] attr_addr(input logic [4:0] col, input logic [7:0] ln);
        return 13'(avpg_pkg::BITMAP_BYTES) + {ln[7:3], 5'b0} + col;
    endfunction

    function automatic void render_expected(input t_video_op op);
        logic [7:0]  bits;
        logic [7:0]  attr;
        logic [1:0]  pal;
        logic        flip;
        logic [3:0]  idx;
        logic [23:0] rgb;
        t_pixel      pix;
        if (op.command == avpg_pkg::CMD_WRITE) begin
            if (op.address < avpg_pkg::STORE_BYTES) begin
                screen_copy[op.address] = op.write_data;
            end
            return;
        end
        if (op.line >= avpg_pkg::SCREEN_LINES) begin
            return;
        end
        pal  = (palette_copy > PAL_MONO) ? PAL_MONO : palette_copy;
        bits = screen_copy[bitmap_addr(op.cell_column, op.line)];
        attr = screen_copy[attr_addr(op.cell_column, op.line)];
        flip = attr[7] & op.flash_phase;
        for (int px = 0; px < 8; px++) begin
            idx = {attr[6], (bits[7 - px] ^ flip) ? attr[2:0] : attr[5:3]};
            rgb = SHADE[pal][idx];
            pix.red     = rgb[23:16];
            pix.green   = rgb[15:8];
            pix.blue    = rgb[7:0];
            pix.pixel_x = {op.cell_column, 3'(px)};
            pix.pixel_y = op.line;
            pix.last    = (px == 7);
            expected_pixels.push_back(pix);
        end
    endfunction

    function automatic void compare_field(input string field_name, input int unsigned want,
                                          input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", field_name, want, got);
            error_count++;
        end
    endfunction

    function automatic void queue_write(input logic [12:0] addr, input logic [7:0] data);
        t_video_op op;
        op.command     = avpg_pkg::CMD_WRITE;
        op.address     = addr;
        op.write_data  = data;
        op.cell_column = 5'($urandom);
        op.line        = 8'($urandom);
        op.flash_phase = 1'($urandom);
        pending_ops.push_back(op);
        if (addr < avpg_pkg::STORE_BYTES) begin
            byte_written[addr] = 1'b1;
            ops_counted++;
        end
    endfunction

    // fill any unwritten byte of the cell before rendering it
    function automatic void queue_render(input logic [4:0] col, input logic [7:0] ln,
                                         input logic phase);
        t_video_op op;
        if (ln < avpg_pkg::SCREEN_LINES) begin
            if (!byte_written[bitmap_addr(col, ln)]) begin
                queue_write(bitmap_addr(col, ln), 8'($urandom));
            end
            if (!byte_written[attr_addr(col, ln)]) begin
                queue_write(attr_addr(col, ln), 8'($urandom));
            end
            ops_counted++;
        end
        op.command     = avpg_pkg::CMD_RENDER;
        op.address     = 13'($urandom);
        op.write_data  = 8'($urandom);
        op.cell_column = col;
        op.line        = ln;
        op.flash_phase = phase;
        pending_ops.push_back(op);
    endfunction

    function automatic void queue_random_op();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            queue_render(5'($urandom), 8'($urandom_range(0, avpg_pkg::SCREEN_LINES - 1)),
                         1'($urandom));
        end else if (pick < 62) begin
            queue_render(5'($urandom_range(0, 3)), 8'($urandom_range(0, 15)), 1'($urandom));
        end else if (pick < 72) begin
            queue_write(13'($urandom_range(0, avpg_pkg::STORE_BYTES - 1)), 8'($urandom));
        end else if (pick < 86) begin
            queue_write(13'($urandom_range(avpg_pkg::BITMAP_BYTES, avpg_pkg::STORE_BYTES - 1)),
                        8'($urandom));
        end else if (pick < 93) begin
            queue_write(13'($urandom_range(avpg_pkg::STORE_BYTES, 8191)), 8'($urandom));
        end else begin
            queue_render(5'($urandom), 8'($urandom_range(avpg_pkg::SCREEN_LINES, 255)),
                         1'($urandom));
        end
    endfunction

    task automatic wait_for_drain();
        do @(posedge i_clk);
        while (pending_ops.size() != 0 || s_axis_tvalid || expected_pixels.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_palette(input logic [1:0] sel);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= sel;
        palette_copy = sel;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                render_expected(op_on_bus);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_ops.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    op_on_bus = pending_ops.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= op_on_bus.command;
                    s_axis_tdata  <= {5'b0, op_on_bus.flash_phase, op_on_bus.line,
                                      op_on_bus.cell_column, op_on_bus.write_data,
                                      op_on_bus.address};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : pixel_monitor
        t_pixel want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_pixels.size() == 0) begin
                    $error("unexpected pixel beat: tdata %h tlast %b", m_axis_tdata, m_axis_tlast);
                    error_count++;
                end else begin
                    want = expected_pixels.pop_front();
                    compare_field("red", want.red, m_axis_tdata[7:0]);
                    compare_field("green", want.green, m_axis_tdata[15:8]);
                    compare_field("blue", want.blue, m_axis_tdata[23:16]);
                    compare_field("pixel_x", want.pixel_x, m_axis_tdata[31:24]);
                    compare_field("pixel_y", want.pixel_y, m_axis_tdata[39:32]);
                    compare_field("last", want.last, m_axis_tlast);
                end
            end
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                    || i_cfg_wr_en) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("tb_attribute_video_pixel_generator failed");
        $finish;
    end

    initial begin : stimulus
        logic [1:0] phase_palette [6];
        phase_palette = '{avpg_pkg::PAL_ALTERNATE, PAL_MONO, PAL_MONO_ALIAS,
                          avpg_pkg::PAL_STANDARD, PAL_MONO, avpg_pkg::PAL_ALTERNATE};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct = 38;
        recv_idle_pct = 46;

        // corner cells, flash swap, bright paper, ignored writes, off-screen lines
        queue_write(13'd0, 8'hA5);
        queue_write(13'(avpg_pkg::BITMAP_BYTES), 8'h0F);
        queue_render(5'd0, 8'd0, 1'b0);
        queue_write(13'(avpg_pkg::BITMAP_BYTES), 8'hC7);
        queue_render(5'd0, 8'd0, 1'b1);
        queue_render(5'd0, 8'd0, 1'b0);
        queue_write(bitmap_addr(5'd31, 8'd191), 8'hFF);
        queue_write(attr_addr(5'd31, 8'd191), 8'h00);
        queue_render(5'd31, 8'd191, 1'b1);
        queue_write(attr_addr(5'd31, 8'd191), 8'hFF);
        queue_render(5'd31, 8'd191, 1'b1);
        queue_render(5'd31, 8'd191, 1'b0);
        queue_write(13'(avpg_pkg::STORE_BYTES), 8'h5A);
        queue_write(13'h1FFF, 8'h00);
        queue_render(5'd31, 8'd191, 1'b0);
        queue_render(5'd0, 8'(avpg_pkg::SCREEN_LINES), 1'b0);
        queue_render(5'd31, 8'd255, 1'b1);
        queue_write(bitmap_addr(5'd17, 8'd100), 8'h00);
        queue_write(attr_addr(5'd17, 8'd100), 8'h78);
        queue_render(5'd17, 8'd100, 1'b1);
        wait_for_drain();

        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 2) begin
                send_idle_pct = 46;
                recv_idle_pct = 38;
            end else if (ph == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            set_palette(phase_palette[ph]);
            ops_counted = 0;
            while (ops_counted < ITEMS_PER_PHASE) begin
                queue_random_op();
            end
            wait_for_drain();
        end

        if (error_count == 0) begin
            $display("tb_attribute_video_pixel_generator passed");
        end else begin
            $display("tb_attribute_video_pixel_generator failed");
        end
        $finish;
    end

endmodule
